### rtl/arf_pkg.sv
// ----------------------------------------------------------------------------
// arf_pkg
// shared widths, register indexes and types for the arma residual filter
// ----------------------------------------------------------------------------
package arf_pkg;

  localparam int LAGS       = 3;
  localparam int LAG_W      = $clog2(LAGS);
  localparam int DATA_W     = 32;
  localparam int COEF_W     = 18;
  localparam int FRAC_W     = 16;
  localparam int SUM_W      = 64;
  localparam int ACC_W      = 56;
  localparam int TAP_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int FIFO_DEPTH = 2;
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

  localparam int AR_TAPS_DEF = 3;
  localparam int MA_TAPS_DEF = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CONSTANT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AR_1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AR_2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AR_3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MA_1     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MA_2     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MA_3     = 3'd6;

  typedef struct packed {
    logic [DATA_W-1:0]            constant_term;
    logic [LAGS-1:0][COEF_W-1:0]  ar_coef;
    logic [LAGS-1:0][COEF_W-1:0]  ma_coef;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] sample_value;
    logic              start_of_series;
  } item_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              full;
  } front_status_t;

endpackage

### rtl/arma_residual_filter_core.sv
// ----------------------------------------------------------------------------
// arma_residual_filter_core
// arma one-step residual filter with running conditional sum of squares
// ----------------------------------------------------------------------------
// input channel: in_valid / in_ready move one sample word (sample_value in
//   q16.16, start_of_series clears both lag histories and the sum first)
// output channel: out_valid / out_ready move one result word per sample:
//   residual_value (q16.16, saturated) and sum_of_squares (q32.32, sticky
//   at all ones on overflow)
// config port: cfg_we writes cfg_data to register cfg_index at the clock
//   edge; 0 constant, 1..3 ar coefficients, 4..6 ma coefficients (q2.16);
//   other indexes are ignored; write only while the filter is idle
// throughput: one sample every AR_TAPS + MA_TAPS + 5 cycles (11 with the
//   default orders, 4 with no taps), set by the single shared 32x32
//   multiplier that serves every tap and then the square
// latency: AR_TAPS + MA_TAPS + 5 cycles from acceptance to out_valid
//   (4 with no taps)
// a two-entry queue in front keeps taking samples while the back end
//   works; a stalled receiver holds the result word in the output register
//   and the back end waits with the next result until it is taken
// reset: synchronous; registers, histories, sum and queue are cleared,
//   no result word is pending
// ----------------------------------------------------------------------------
module arma_residual_filter_core #(
  parameter int AR_TAPS = arf_pkg::AR_TAPS_DEF,
  parameter int MA_TAPS = arf_pkg::MA_TAPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [arf_pkg::DATA_W-1:0]      sample_value,
  input  logic                            start_of_series,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [arf_pkg::DATA_W-1:0]      residual_value,
  output logic [arf_pkg::SUM_W-1:0]       sum_of_squares,
  input  logic                            cfg_we,
  input  logic [arf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [arf_pkg::DATA_W-1:0]      cfg_data
);

  // configuration registers
  arf_pkg::cfg_t          cfg;

  // queue between front and back
  arf_pkg::item_t         in_item;
  arf_pkg::item_t         q_item;
  logic                   q_valid;
  logic                   pop;
  arf_pkg::front_status_t front_status;

  assign in_item.sample_value    = sample_value;
  assign in_item.start_of_series = start_of_series;

  // register writes, coefficients keep their low bits only
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        arf_pkg::REG_CONSTANT: cfg.constant_term <= cfg_data;
        arf_pkg::REG_AR_1:     cfg.ar_coef[0]    <= cfg_data[arf_pkg::COEF_W-1:0];
        arf_pkg::REG_AR_2:     cfg.ar_coef[1]    <= cfg_data[arf_pkg::COEF_W-1:0];
        arf_pkg::REG_AR_3:     cfg.ar_coef[2]    <= cfg_data[arf_pkg::COEF_W-1:0];
        arf_pkg::REG_MA_1:     cfg.ma_coef[0]    <= cfg_data[arf_pkg::COEF_W-1:0];
        arf_pkg::REG_MA_2:     cfg.ma_coef[1]    <= cfg_data[arf_pkg::COEF_W-1:0];
        arf_pkg::REG_MA_3:     cfg.ma_coef[2]    <= cfg_data[arf_pkg::COEF_W-1:0];
        default:               cfg               <= cfg;
      endcase
    end
  end

  // front: accepts and queues sample words
  arf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop),
    .status   (front_status)
  );

  // back: taps, rounding, square and sum on the shared multiplier
  arf_back #(
    .AR_TAPS (AR_TAPS),
    .MA_TAPS (MA_TAPS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .residual_value (residual_value),
    .sum_of_squares (sum_of_squares)
  );

`ifndef SYNTHESIS
  // the back end only takes a word that the queue holds
  a_pop_needs_word: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("back end popped an empty queue");

  // queue fill never runs past its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    front_status.fill <= arf_pkg::FILL_W'(arf_pkg::FIFO_DEPTH))
    else $error("queue fill beyond depth");

  // after reset no result is pending and the queue is empty
  a_reset_clean: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !q_valid))
    else $error("state left over after reset");
`endif

endmodule

### rtl/arf_front.sv
// ----------------------------------------------------------------------------
// arf_front
// input side: takes sample words and queues them for the back end
// ----------------------------------------------------------------------------
module arf_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  arf_pkg::item_t        in_item,
  output logic                  q_valid,
  output arf_pkg::item_t        q_item,
  input  logic                  pop,
  output arf_pkg::front_status_t status
);

  localparam int PTR_W = (arf_pkg::FIFO_DEPTH > 1) ? $clog2(arf_pkg::FIFO_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(arf_pkg::FIFO_DEPTH - 1);

  arf_pkg::item_t             mem [arf_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]           wr_ptr;
  logic [PTR_W-1:0]           rd_ptr;
  logic [arf_pkg::FILL_W-1:0] fill;
  logic                       push;

  assign in_ready    = (fill != arf_pkg::FILL_W'(arf_pkg::FIFO_DEPTH));
  assign push        = in_valid && in_ready;
  assign q_valid     = (fill != '0);
  assign q_item      = mem[rd_ptr];
  assign status.fill = fill;
  assign status.full = !in_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### rtl/arf_back.sv
// ----------------------------------------------------------------------------
// arf_back
// sequencer with one shared multiplier: taps, rounding, square and sum
// ----------------------------------------------------------------------------
module arf_back #(
  parameter int AR_TAPS = arf_pkg::AR_TAPS_DEF,
  parameter int MA_TAPS = arf_pkg::MA_TAPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  arf_pkg::cfg_t                cfg,
  input  logic                         q_valid,
  input  arf_pkg::item_t               q_item,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [arf_pkg::DATA_W-1:0]   residual_value,
  output logic [arf_pkg::SUM_W-1:0]    sum_of_squares
);

  localparam int DW     = arf_pkg::DATA_W;
  localparam int CW     = arf_pkg::COEF_W;
  localparam int AW     = arf_pkg::ACC_W;
  localparam int FW     = arf_pkg::FRAC_W;
  localparam int SW     = arf_pkg::SUM_W;
  localparam int TW     = arf_pkg::TAP_W;
  localparam int LAGS   = arf_pkg::LAGS;
  localparam int NTAPS  = AR_TAPS + MA_TAPS;
  localparam int RW     = AW - FW;
  localparam logic [TW-1:0] LAST_TAP = TW'(NTAPS - 1);
  localparam logic [TW-1:0] AR_N     = TW'(AR_TAPS);

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_DRAIN, S_ROUND, S_SQUARE, S_SUM
  } state_t;

  state_t                       state;
  logic [TW-1:0]                tap_idx;
  logic [DW-1:0]                x_reg;
  logic signed [AW-1:0]         acc;
  logic signed [2*DW-1:0]       prod;
  logic [DW-1:0]                r_reg;
  logic [LAGS-1:0][DW-1:0]      sh;
  logic [LAGS-1:0][DW-1:0]      rh;
  logic [SW-1:0]                sum;

  logic                         out_free;
  logic                         is_ar;
  logic [TW-1:0]                lag_full;
  logic [arf_pkg::LAG_W-1:0]    lag;
  logic [CW-1:0]                coef;
  logic signed [DW-1:0]         mul_a;
  logic signed [DW-1:0]         mul_b;
  logic signed [2*DW-1:0]       prod_full;
  logic signed [DW:0]           diff;
  logic signed [AW-1:0]         load_acc;
  logic signed [AW-1:0]         acc_sub;
  logic signed [AW-1:0]         biased;
  logic [RW-1:0]                r_full;
  logic [DW-1:0]                r_sat;
  logic [SW:0]                  sum_wide;
  logic [SW-1:0]                sum_next;

  assign pop      = (state == S_IDLE) && q_valid;
  assign out_free = !out_valid || out_ready;

  // operand select for the shared multiplier
  always_comb begin
    is_ar    = (tap_idx < AR_N);
    lag_full = is_ar ? tap_idx : tap_idx - AR_N;
    lag      = lag_full[arf_pkg::LAG_W-1:0];
    coef     = is_ar ? cfg.ar_coef[lag] : cfg.ma_coef[lag];
    if (state == S_SQUARE) begin
      mul_a = r_reg;
      mul_b = r_reg;
    end else begin
      mul_a = {{(DW-CW){coef[CW-1]}}, coef};
      mul_b = is_ar ? sh[lag] : rh[lag];
    end
    prod_full = mul_a * mul_b;
  end

  always_comb begin
    diff     = $signed({q_item.sample_value[DW-1], q_item.sample_value})
             - $signed({cfg.constant_term[DW-1], cfg.constant_term});
    load_acc = {{(AW-DW-1-FW){diff[DW]}}, diff, {FW{1'b0}}};
    acc_sub  = acc - prod[AW-1:0];
    // round half up, then saturate
    biased   = acc + AW'(1 << (FW - 1));
    r_full   = biased[AW-1:FW];
    if ((&r_full[RW-1:DW-1]) || !(|r_full[RW-1:DW-1])) begin
      r_sat = r_full[DW-1:0];
    end else if (r_full[RW-1]) begin
      r_sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      r_sat = {1'b0, {(DW-1){1'b1}}};
    end
    sum_wide = {1'b0, sum} + {1'b0, prod[SW-1:0]};
    sum_next = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap_idx   <= '0;
      out_valid <= 1'b0;
      sh        <= '0;
      rh        <= '0;
      sum       <= '0;
    end else begin
      // in the sum state a taken word is replaced by the next one
      if (out_valid && out_ready && (state != S_SUM)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            x_reg   <= q_item.sample_value;
            acc     <= load_acc;
            tap_idx <= '0;
            if (q_item.start_of_series) begin
              sh  <= '0;
              rh  <= '0;
              sum <= '0;
            end
            state <= (NTAPS == 0) ? S_ROUND : S_MAC;
          end
        end
        S_MAC: begin
          prod <= prod_full;
          if (tap_idx != '0) begin
            acc <= acc_sub;
          end
          if (tap_idx == LAST_TAP) begin
            state <= S_DRAIN;
          end else begin
            tap_idx <= tap_idx + 1'b1;
          end
        end
        S_DRAIN: begin
          acc   <= acc_sub;
          state <= S_ROUND;
        end
        S_ROUND: begin
          r_reg <= r_sat;
          state <= S_SQUARE;
        end
        S_SQUARE: begin
          prod  <= prod_full;
          state <= S_SUM;
        end
        S_SUM: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            residual_value <= r_reg;
            sum_of_squares <= sum_next;
            sum            <= sum_next;
            sh             <= {sh[LAGS-2:0], x_reg};
            rh             <= {rh[LAGS-2:0], r_reg};
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
